// ----- rtl/core/ptf_pkg.sv -----
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared byte width and character codes for the PO catalog text filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ptf_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] CH_M       = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_S       = 8'h73;
    localparam logic [BYTE_W-1:0] CH_G       = 8'h67;
    localparam logic [BYTE_W-1:0] CH_T       = 8'h74;
    localparam logic [BYTE_W-1:0] CH_R       = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

endpackage

`default_nettype wire

// ----- rtl/core/ptf_parser.sv -----
// ----------------------------------------------------------------------------
// ptf_parser
// Parse state of the PO catalog filter and the per-byte pass or hide decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ptf_parser
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [ptf_pkg::BYTE_W-1:0] byte_in,
    output logic      [ptf_pkg::BYTE_W-1:0] byte_out,
    output logic                            hdr_seen
);

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_M          = 4'd1,
        PH_MS         = 4'd2,
        PH_MSG        = 4'd3,
        PH_MSGS       = 4'd4,
        PH_MSGST      = 4'd5,
        PH_MSGSTR     = 4'd6,
        PH_INDEX      = 4'd7,
        PH_HIDE       = 4'd8,
        PH_ECHO       = 4'd9,
        PH_AFTER_ECHO = 4'd10
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   hdr_reg;
    logic   hdr_next;
    phase_t line_start_phase;

    always_comb
    begin
        if (byte_in == ptf_pkg::CH_HASH)
        begin
            line_start_phase = PH_HIDE;
        end
        else if (byte_in == ptf_pkg::CH_M)
        begin
            line_start_phase = PH_M;
        end
        else
        begin
            line_start_phase = PH_LINE_START;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        byte_out   = ptf_pkg::CH_SPACE;
        unique case (phase_reg)
            PH_M:
            begin
                phase_next = (byte_in == ptf_pkg::CH_S) ? PH_MS : PH_HIDE;
            end
            PH_MS:
            begin
                phase_next = (byte_in == ptf_pkg::CH_G) ? PH_MSG : PH_HIDE;
            end
            PH_MSG:
            begin
                phase_next = (byte_in == ptf_pkg::CH_S) ? PH_MSGS : PH_HIDE;
            end
            PH_MSGS:
            begin
                phase_next = (byte_in == ptf_pkg::CH_T) ? PH_MSGST : PH_HIDE;
            end
            PH_MSGST:
            begin
                phase_next = (byte_in == ptf_pkg::CH_R) ? PH_MSGSTR : PH_HIDE;
            end
            PH_MSGSTR:
            begin
                if (byte_in == ptf_pkg::CH_LBRACK)
                begin
                    phase_next = PH_INDEX;
                end
                else if (hdr_reg)
                begin
                    phase_next = PH_ECHO;
                end
                else
                begin
                    phase_next = PH_HIDE;
                end
                hdr_next = 1'b1;
            end
            PH_INDEX:
            begin
                if (byte_in == ptf_pkg::CH_RBRACK)
                begin
                    phase_next = PH_ECHO;
                end
                else if (byte_in == ptf_pkg::CH_NEWLINE)
                begin
                    phase_next = PH_LINE_START;
                    byte_out   = byte_in;
                end
            end
            PH_HIDE:
            begin
                if (byte_in == ptf_pkg::CH_NEWLINE)
                begin
                    phase_next = PH_LINE_START;
                    byte_out   = byte_in;
                end
            end
            PH_ECHO:
            begin
                if (byte_in == ptf_pkg::CH_NEWLINE)
                begin
                    phase_next = PH_AFTER_ECHO;
                end
                byte_out = byte_in;
            end
            PH_AFTER_ECHO:
            begin
                if (byte_in == ptf_pkg::CH_QUOTE)
                begin
                    phase_next = PH_ECHO;
                    byte_out   = byte_in;
                end
                else
                begin
                    phase_next = line_start_phase;
                end
            end
            default:
            begin
                phase_next = line_start_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            hdr_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
        end
    end

    assign hdr_seen = hdr_reg;

endmodule

`default_nettype wire

// ----- rtl/core/po_translation_text_filter.sv -----
// ----------------------------------------------------------------------------
// po_translation_text_filter
// Byte filter for PO message catalogs: passes translated text, blanks the rest.
// ----------------------------------------------------------------------------
// One byte in, one byte out, in order. An item goes through an input register
// and a result register before it appears on the output, and the block takes
// one item per cycle as long as the output side keeps up; the parse state
// advances by one byte per cycle in the parser while the output is free.
// Hidden bytes come out as a space, except newlines in the hide or index phase.
`default_nettype none

module po_translation_text_filter
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ptf_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [ptf_pkg::BYTE_W-1:0] m_tdata    // [7:0] out_byte
);

    logic                       s1_valid_reg;
    logic [ptf_pkg::BYTE_W-1:0] s1_data_reg;
    logic                       out_valid_reg;
    logic [ptf_pkg::BYTE_W-1:0] out_data_reg;
    logic                       out_free;
    logic                       advance;
    logic [ptf_pkg::BYTE_W-1:0] filt_byte;
    logic                       hdr_seen;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    ptf_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .byte_in  (s1_data_reg),
        .byte_out (filt_byte),
        .hdr_seen (hdr_seen)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= filt_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_hdr_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        $past(hdr_seen) |-> hdr_seen)
        else $error("header flag cleared");

    a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (m_tdata == ptf_pkg::CH_SPACE || m_tdata == $past(s1_data_reg)))
        else $error("output byte is neither space nor the input byte");

    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
